@@ hdl/plae_pkg.sv @@
// shared types, constants and lookup functions of the logical address encoder
package plae_pkg;

	// register indexes of the configuration port
	localparam logic REG_FORMAT   = 1'b0;
	localparam logic REG_CAPACITY = 1'b1;

	// target formats
	localparam logic FMT_LEVEL = 1'b0;
	localparam logic FMT_TYPED = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_BAD  = 2'd1,
		ST_CAP  = 2'd2,
		ST_TYPE = 2'd3
	} status_t;

	// data file kinds
	localparam logic [4:0] KIND_UNKNOWN = 5'd0;
	localparam logic [4:0] KIND_A       = 5'd1;
	localparam logic [4:0] KIND_B       = 5'd2;
	localparam logic [4:0] KIND_BT      = 5'd3;
	localparam logic [4:0] KIND_C       = 5'd4;
	localparam logic [4:0] KIND_D       = 5'd5;
	localparam logic [4:0] KIND_F       = 5'd6;
	localparam logic [4:0] KIND_I       = 5'd7;
	localparam logic [4:0] KIND_O       = 5'd8;
	localparam logic [4:0] KIND_MG      = 5'd9;
	localparam logic [4:0] KIND_N       = 5'd10;
	localparam logic [4:0] KIND_PD      = 5'd11;
	localparam logic [4:0] KIND_R       = 5'd12;
	localparam logic [4:0] KIND_S       = 5'd13;
	localparam logic [4:0] KIND_SC      = 5'd14;
	localparam logic [4:0] KIND_ST      = 5'd15;
	localparam logic [4:0] KIND_T       = 5'd16;

	localparam int          NUM_W            = 20;
	localparam logic [19:0] NUM_LIMIT        = 20'd65535;
	localparam logic [19:0] NUM_ONE_BYTE_MAX = 20'd254;
	localparam logic [7:0]  NUM_ESC          = 8'hff;
	localparam logic [7:0]  FLAG_LEVEL       = 8'h06;
	localparam logic [7:0]  FLAG_LEVEL_SUB   = 8'h0e;
	localparam logic [7:0]  MIN_CAPACITY     = 8'd10;

	// one parsed address handed from the parser to the serializer
	typedef struct packed {
		status_t           status;
		logic [4:0]        kind;
		logic              fmt;
		logic              has_sub;
		logic [NUM_W-1:0]  file_no;
		logic [NUM_W-1:0]  elem_no;
		logic [NUM_W-1:0]  sub_num;
	} job_t;

	// mnemonic table entry, text holds the first character in the low byte
	typedef struct packed {
		logic [4:0]  kind;
		logic [3:0]  len;
		logic [31:0] text;
		logic [7:0]  value;
	} mnem_entry_t;

	localparam int MNEM_ENTRIES = 27;

	localparam mnem_entry_t MNEM_TABLE [MNEM_ENTRIES] = '{
		'{KIND_BT, 4'd3, {8'h00, "n", "o", "c"}, 8'd0},
		'{KIND_BT, 4'd4, {"n", "e", "l", "r"},   8'd1},
		'{KIND_BT, 4'd4, {"n", "e", "l", "d"},   8'd2},
		'{KIND_BT, 4'd2, {16'h0000, "f", "d"},   8'd3},
		'{KIND_BT, 4'd4, {"m", "e", "l", "e"},   8'd4},
		'{KIND_BT, 4'd3, {8'h00, "s", "g", "r"}, 8'd5},
		'{KIND_C,  4'd3, {8'h00, "n", "o", "c"}, 8'd0},
		'{KIND_C,  4'd3, {8'h00, "e", "r", "p"}, 8'd1},
		'{KIND_C,  4'd3, {8'h00, "c", "c", "a"}, 8'd2},
		'{KIND_T,  4'd3, {8'h00, "n", "o", "c"}, 8'd0},
		'{KIND_T,  4'd3, {8'h00, "e", "r", "p"}, 8'd1},
		'{KIND_T,  4'd3, {8'h00, "c", "c", "a"}, 8'd2},
		'{KIND_R,  4'd3, {8'h00, "n", "o", "c"}, 8'd0},
		'{KIND_R,  4'd3, {8'h00, "n", "e", "l"}, 8'd1},
		'{KIND_R,  4'd3, {8'h00, "s", "o", "p"}, 8'd2},
		'{KIND_PD, 4'd3, {8'h00, "n", "o", "c"}, 8'd0},
		'{KIND_PD, 4'd2, {16'h0000, "p", "s"},   8'd2},
		'{KIND_PD, 4'd2, {16'h0000, "p", "k"},   8'd4},
		'{KIND_PD, 4'd2, {16'h0000, "i", "k"},   8'd6},
		'{KIND_PD, 4'd2, {16'h0000, "d", "k"},   8'd8},
		'{KIND_PD, 4'd2, {16'h0000, "v", "p"},   8'd26},
		'{KIND_MG, 4'd3, {8'h00, "n", "o", "c"}, 8'd0},
		'{KIND_MG, 4'd3, {8'h00, "r", "r", "e"}, 8'd1},
		'{KIND_MG, 4'd4, {"n", "e", "l", "r"},   8'd2},
		'{KIND_MG, 4'd4, {"n", "e", "l", "d"},   8'd3},
		'{KIND_ST, 4'd3, {8'h00, "n", "e", "l"}, 8'd0},
		'{KIND_ST, 4'd4, {"a", "t", "a", "d"},   8'd1}
	};

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= "A" && c <= "Z") begin
			r = c + 8'd32;
		end
		return r;
	endfunction

	// type code of a file kind, zero where the kind has none
	function automatic logic [7:0] type_code(input logic [4:0] kind);
		logic [7:0] r;
		unique case (kind)
			KIND_A:  r = 8'h8e;
			KIND_B:  r = 8'h85;
			KIND_C:  r = 8'h87;
			KIND_D:  r = 8'h8f;
			KIND_F:  r = 8'h8a;
			KIND_I:  r = 8'h8c;
			KIND_O:  r = 8'h8b;
			KIND_N:  r = 8'h89;
			KIND_R:  r = 8'h88;
			KIND_S:  r = 8'h84;
			KIND_ST: r = 8'h8d;
			KIND_T:  r = 8'h86;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// match lowered text against the table, returns {found, value}
	function automatic logic [8:0] mnem_lookup(input logic [4:0] kind, input logic [3:0] len,
			input logic [31:0] chars);
		logic [31:0] masked;
		logic [8:0]  r;
		masked = '0;
		r = '0;
		for (int j = 0; j < 4; j++) begin
			if (4'(j) < len) begin
				masked[j*8 +: 8] = chars[j*8 +: 8];
			end
		end
		for (int i = MNEM_ENTRIES - 1; i >= 0; i--) begin
			if (MNEM_TABLE[i].kind == kind && MNEM_TABLE[i].len == len &&
					MNEM_TABLE[i].text == masked) begin
				r = {1'b1, MNEM_TABLE[i].value};
			end
		end
		return r;
	endfunction

endpackage

@@ hdl/plae_front.sv @@
// address parser: takes one character per transfer and builds one job per address
module plae_front import plae_pkg::*; #(
	parameter int MNEMONIC_CHARS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] char_in,
	input  logic       last_char,
	input  logic       accept,
	input  logic       fmt,
	input  logic [7:0] capacity,
	output logic       push,
	output job_t       job
);

	localparam int MLW = $clog2(MNEMONIC_CHARS + 1);
	localparam int MIW = $clog2(MNEMONIC_CHARS);

	typedef enum logic [2:0] {
		PH_TYPE, PH_TYPE2, PH_FILE_FIRST, PH_FILE, PH_ELEM, PH_BIT, PH_MNEM, PH_DONE
	} phase_t;

	phase_t           ph_q, n_ph, f_ph;
	logic [4:0]       kind_q, n_kind, f_kind;
	logic [NUM_W-1:0] file_q, n_file;
	logic [NUM_W-1:0] elem_q, n_elem;
	logic [NUM_W-1:0] sub_q, n_sub, f_sub;
	logic             hs_q, n_hs;
	logic [MLW-1:0]   mlen_q, n_mlen, look_len;
	logic             err_q, n_err, f_err;
	logic [7:0]       mbuf_q [MNEMONIC_CHARS];
	logic [7:0]       bufv [MNEMONIC_CHARS];

	logic [7:0] l;
	logic       dig;
	logic [3:0] dv;
	logic       wr_m;
	logic [8:0] mres;

	function automatic logic [NUM_W-1:0] num10(input logic [NUM_W-1:0] v, input logic [3:0] d);
		return {v[NUM_W-4:0], 3'b000} + {v[NUM_W-2:0], 1'b0} + {{(NUM_W-4){1'b0}}, d};
	endfunction

	assign l   = to_lower(char_in);
	assign dig = (char_in >= "0") && (char_in <= "9");
	assign dv  = char_in[3:0];

	// mnemonic buffer as seen after this character is stored
	assign wr_m     = (ph_q == PH_MNEM) && (char_in != 8'd0) && (mlen_q < MLW'(MNEMONIC_CHARS));
	assign look_len = mlen_q + MLW'(wr_m);

	always_comb begin
		for (int j = 0; j < MNEMONIC_CHARS; j++) begin
			bufv[j] = (wr_m && mlen_q == MLW'(j)) ? l : mbuf_q[j];
		end
	end

	assign mres = mnem_lookup(kind_q, 4'(look_len), {bufv[3], bufv[2], bufv[1], bufv[0]});

	// one parse step on the incoming character
	always_comb begin
		n_ph   = ph_q;
		n_kind = kind_q;
		n_file = file_q;
		n_elem = elem_q;
		n_sub  = sub_q;
		n_hs   = hs_q;
		n_mlen = mlen_q;
		n_err  = err_q;
		unique case (ph_q)
			PH_TYPE: begin
				n_ph = PH_FILE_FIRST;
				unique case (l)
					"a": n_kind = KIND_A;
					"b": begin
						n_kind = KIND_B;
						n_ph = PH_TYPE2;
					end
					"c": n_kind = KIND_C;
					"d": n_kind = KIND_D;
					"f": n_kind = KIND_F;
					"i": n_kind = KIND_I;
					"m": begin
						n_kind = KIND_MG;
						n_ph = PH_TYPE2;
					end
					"n": n_kind = KIND_N;
					"o": n_kind = KIND_O;
					"p": begin
						n_kind = KIND_PD;
						n_ph = PH_TYPE2;
					end
					"r": n_kind = KIND_R;
					"s": begin
						n_kind = KIND_S;
						n_ph = PH_TYPE2;
					end
					"t": n_kind = KIND_T;
					default: begin
						n_kind = KIND_UNKNOWN;
						n_err = 1'b1;
						n_ph = PH_DONE;
					end
				endcase
			end
			PH_TYPE2: begin
				if (kind_q == KIND_B || kind_q == KIND_S) begin
					if (dig) begin
						n_file = {{(NUM_W-4){1'b0}}, dv};
						n_ph = PH_FILE;
					end else if (kind_q == KIND_B && l == "t") begin
						n_kind = KIND_BT;
						n_ph = PH_FILE_FIRST;
					end else if (kind_q == KIND_S && l == "c") begin
						n_kind = KIND_SC;
						n_ph = PH_FILE_FIRST;
					end else if (kind_q == KIND_S && l == "t") begin
						n_kind = KIND_ST;
						n_ph = PH_FILE_FIRST;
					end else begin
						n_kind = KIND_UNKNOWN;
						n_err = 1'b1;
						n_ph = PH_DONE;
					end
				end else if ((kind_q == KIND_MG && l == "g") || (kind_q == KIND_PD && l == "d")) begin
					n_ph = PH_FILE_FIRST;
				end else begin
					n_kind = KIND_UNKNOWN;
					n_err = 1'b1;
					n_ph = PH_DONE;
				end
			end
			PH_FILE_FIRST: begin
				if (dig) begin
					n_file = {{(NUM_W-4){1'b0}}, dv};
					n_ph = PH_FILE;
				end else begin
					n_err = 1'b1;
					n_ph = PH_DONE;
				end
			end
			PH_FILE: begin
				if (dig && file_q < NUM_LIMIT) begin
					n_file = num10(file_q, dv);
				end else if (char_in == ":") begin
					n_ph = PH_ELEM;
				end else begin
					n_err = 1'b1;
					n_ph = PH_DONE;
				end
			end
			PH_ELEM: begin
				if (dig && elem_q < NUM_LIMIT) begin
					n_elem = num10(elem_q, dv);
				end else if (char_in == "/") begin
					n_hs = 1'b1;
					n_sub = '0;
					n_ph = PH_BIT;
				end else if (char_in == ".") begin
					n_hs = 1'b1;
					n_ph = PH_MNEM;
				end else if (char_in == 8'd0) begin
					n_ph = PH_DONE;
				end else begin
					n_err = 1'b1;
					n_ph = PH_DONE;
				end
			end
			PH_BIT: begin
				if (dig && sub_q < NUM_LIMIT) begin
					n_sub = num10(sub_q, dv);
				end else begin
					n_ph = PH_DONE;
				end
			end
			PH_MNEM: begin
				if (char_in == 8'd0) begin
					n_ph = PH_DONE;
					if (mres[8]) begin
						n_sub = {{(NUM_W-8){1'b0}}, mres[7:0]};
					end else begin
						n_err = 1'b1;
					end
				end else if (wr_m) begin
					n_mlen = look_len;
				end else begin
					n_err = 1'b1;
					n_ph = PH_DONE;
				end
			end
			PH_DONE: ;
			default: ;
		endcase
	end

	// end of address: close whatever phase is still open as if a zero byte came
	always_comb begin
		f_ph   = n_ph;
		f_kind = n_kind;
		f_sub  = n_sub;
		f_err  = n_err;
		unique case (n_ph)
			PH_TYPE, PH_TYPE2: begin
				f_kind = KIND_UNKNOWN;
				f_err = 1'b1;
			end
			PH_FILE_FIRST, PH_FILE: f_err = 1'b1;
			PH_MNEM: begin
				if (mres[8]) begin
					f_sub = {{(NUM_W-8){1'b0}}, mres[7:0]};
				end else begin
					f_err = 1'b1;
				end
			end
			default: ;
		endcase
		f_ph = PH_DONE;
	end

	assign push = accept && last_char;

	always_comb begin
		job.kind     = f_kind;
		job.fmt      = fmt;
		job.has_sub  = n_hs;
		job.file_no  = n_file;
		job.elem_no  = n_elem;
		job.sub_num  = f_sub;
		if (f_err && f_ph == PH_DONE) begin
			job.status = ST_BAD;
		end else if (capacity < MIN_CAPACITY) begin
			job.status = ST_CAP;
		end else if (fmt == FMT_TYPED && type_code(f_kind) == 8'h00) begin
			job.status = ST_TYPE;
		end else begin
			job.status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_TYPE;
			kind_q <= KIND_UNKNOWN;
			file_q <= '0;
			elem_q <= '0;
			sub_q  <= '0;
			hs_q   <= 1'b0;
			mlen_q <= '0;
			err_q  <= 1'b0;
		end else if (accept) begin
			if (last_char) begin
				ph_q   <= PH_TYPE;
				kind_q <= KIND_UNKNOWN;
				file_q <= '0;
				elem_q <= '0;
				sub_q  <= '0;
				hs_q   <= 1'b0;
				mlen_q <= '0;
				err_q  <= 1'b0;
			end else begin
				ph_q   <= n_ph;
				kind_q <= n_kind;
				file_q <= n_file;
				elem_q <= n_elem;
				sub_q  <= n_sub;
				hs_q   <= n_hs;
				mlen_q <= n_mlen;
				err_q  <= n_err;
			end
		end
	end

	// mnemonic text, stored lowered
	always_ff @(posedge clk) begin
		if (accept && wr_m) begin
			mbuf_q[mlen_q[MIW-1:0]] <= l;
		end
	end

endmodule

@@ hdl/plae_queue.sv @@
// two-entry job queue between parser and serializer
module plae_queue import plae_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  job_t  din,
	output logic  full,
	input  logic  pop,
	output job_t  dout,
	output logic  empty
);

	job_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

@@ hdl/plae_back.sv @@
// serializer: turns one job into its run of encoded bytes
module plae_back import plae_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       job,
	input  logic       avail,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic [6:0] m_tuser,
	output logic       m_tlast
);

	job_t             cur_q;
	logic             busy_q;
	logic [1:0]       fi_q;
	logic [1:0]       bi_q;
	logic             tvalid_q;
	logic [7:0]       tdata_q;
	logic [6:0]       tuser_q;
	logic             tlast_q;

	logic [NUM_W-1:0] fval;
	logic [1:0]       last_fi;
	logic             big;
	logic             field_end;
	logic             byte_last;
	logic [7:0]       byte_val;
	logic             adv;

	// field sequence: level form flag, file, element, sub if present; typed form file, code, element, sub
	always_comb begin
		fval = '0;
		if (cur_q.fmt == FMT_LEVEL) begin
			unique case (fi_q)
				2'd0: fval = {{(NUM_W-8){1'b0}}, cur_q.has_sub ? FLAG_LEVEL_SUB : FLAG_LEVEL};
				2'd1: fval = cur_q.file_no;
				2'd2: fval = cur_q.elem_no;
				default: fval = cur_q.sub_num;
			endcase
			last_fi = cur_q.has_sub ? 2'd3 : 2'd2;
		end else begin
			unique case (fi_q)
				2'd0: fval = cur_q.file_no;
				2'd1: fval = {{(NUM_W-8){1'b0}}, type_code(cur_q.kind)};
				2'd2: fval = cur_q.elem_no;
				default: fval = cur_q.has_sub ? cur_q.sub_num : '0;
			endcase
			last_fi = 2'd3;
		end
	end

	// a number above 254 goes out as escape, low byte, high byte
	assign big       = fval > NUM_ONE_BYTE_MAX;
	assign field_end = big ? (bi_q == 2'd2) : (bi_q == 2'd0);
	assign byte_last = (cur_q.status != ST_OK) || (field_end && fi_q == last_fi);

	always_comb begin
		if (cur_q.status != ST_OK) begin
			byte_val = 8'h00;
		end else begin
			unique case (bi_q)
				2'd0: byte_val = big ? NUM_ESC : fval[7:0];
				2'd1: byte_val = fval[7:0];
				default: byte_val = fval[15:8];
			endcase
		end
	end

	assign adv = busy_q && (!tvalid_q || m_tready);
	assign pop = avail && (!busy_q || (adv && byte_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			fi_q     <= 2'd0;
			bi_q     <= 2'd0;
			tvalid_q <= 1'b0;
		end else begin
			if (adv) begin
				tvalid_q <= 1'b1;
			end else if (m_tready) begin
				tvalid_q <= 1'b0;
			end
			if (pop) begin
				busy_q <= 1'b1;
				fi_q   <= 2'd0;
				bi_q   <= 2'd0;
			end else if (adv) begin
				if (byte_last) begin
					busy_q <= 1'b0;
				end
				if (field_end) begin
					fi_q <= fi_q + 2'd1;
					bi_q <= 2'd0;
				end else begin
					bi_q <= bi_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= job;
		end
		if (adv) begin
			tdata_q <= byte_val;
			tuser_q <= {cur_q.kind, cur_q.status};
			tlast_q <= byte_last;
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;
	assign m_tlast  = tlast_q;

endmodule

@@ hdl/pccc_logical_address_encoder.sv @@
// top level of the data-table logical address encoder
//
// channel   dir   handshake           payload
// s_        in    tvalid/tready       tdata char_in, tlast last_char
// m_        out   tvalid/tready       tdata out_byte, tlast out_last, tuser status/kind
// cfg_      in    cfg_we              cfg_index register, cfg_data value
//
// one character is taken per cycle while s_tready is high; the parser hands each finished
// address to a two-entry job queue, so the input keeps flowing while earlier runs drain
// an address leaves as 1 to 10 bytes, one byte per cycle from the serializer while m_tready
// is high; back to back runs follow without a gap
// s_tready drops only while the job queue is full, m_ stalls hold the output register
// reset clears the parse state, the queue and the output valid; registers return to
// level form and a capacity of 12
module pccc_logical_address_encoder import plae_pkg::*; #(
	parameter int MNEMONIC_CHARS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_in
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [6:0] m_tuser,   // [1:0] status, [6:2] data_file_kind
	output logic       m_tlast,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	// configuration registers
	logic       fmt_q;
	logic [7:0] cap_q;

	// parser to queue
	logic s_accept;
	logic push;
	job_t push_job;

	// queue to serializer
	logic q_full;
	logic q_empty;
	logic pop;
	job_t head_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_LEVEL;
			cap_q <= 8'd12;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FORMAT:   fmt_q <= cfg_data[0];
				REG_CAPACITY: cap_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input is held off only when no queue slot is free for a finished address
	assign s_tready = !q_full;
	assign s_accept = s_tvalid && s_tready;

	plae_front #(
		.MNEMONIC_CHARS(MNEMONIC_CHARS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.char_in  (s_tdata),
		.last_char(s_tlast),
		.accept   (s_accept),
		.fmt      (fmt_q),
		.capacity (cap_q),
		.push     (push),
		.job      (push_job)
	);

	plae_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (push_job),
		.full  (q_full),
		.pop   (pop),
		.dout  (head_job),
		.empty (q_empty)
	);

	// serializer owns the output register
	plae_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.job     (head_job),
		.avail   (!q_empty),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

@@ test/pccc_logical_address_encoder_test.sv @@
// self-checking testbench of the data-table logical address encoder
module pccc_logical_address_encoder_test;
	import plae_pkg::*;

	// quiet cycles after the last expected byte before the block counts as idle
	localparam int QUIET_CYCLES = 16;
	// cycles without any transfer before the run is declared hung
	localparam int HANG_LIMIT   = 2000;
	// characters of random stimulus per register setting
	localparam int PHASE_CHARS  = 40;
	localparam int NUM_PHASES   = 10;
	localparam int MNEM_COUNT   = 27;

	// where the parser stands inside the address text
	typedef enum {
		P_TYPE, P_TYPE2, P_FILE_FIRST, P_FILE, P_ELEM, P_BIT, P_MNEM, P_DONE
	} parse_phase_t;

	// one encoded byte as it should leave the master side
	typedef struct {
		logic [7:0] data;
		logic       last;
		status_t    status;
		logic [4:0] kind;
	} enc_byte_t;

	// address parser and encoder mirror plus the queue of bytes still owed by the block
	class addr_scoreboard;
		logic         fmt;
		logic [7:0]   capacity;
		parse_phase_t phase;
		logic [4:0]   kind;
		logic [19:0]  file_no;
		logic [19:0]  elem_no;
		logic [19:0]  sub_num;
		logic         has_sub;
		logic [7:0]   mnem [4];
		int           mnem_len;
		logic         err;
		logic [7:0]   run_q[$];
		enc_byte_t    expected_q[$];
		int           fails;
		int           addresses;
		int           rejected;
		int           bytes_checked;

		function new();
			fmt = FMT_LEVEL;
			capacity = 8'd12;
			fails = 0;
			addresses = 0;
			rejected = 0;
			bytes_checked = 0;
			clear();
		endfunction

		function void clear();
			phase = P_TYPE;
			kind = KIND_UNKNOWN;
			file_no = '0;
			elem_no = '0;
			sub_num = '0;
			has_sub = 1'b0;
			foreach (mnem[j]) mnem[j] = 8'h00;
			mnem_len = 0;
			err = 1'b0;
		endfunction

		function logic [7:0] lower(logic [7:0] c);
			return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
		endfunction

		function logic is_digit(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function logic [19:0] shift_in(logic [19:0] v, logic [7:0] c);
			return v * 20'd10 + {12'd0, c - 8'h30};
		endfunction

		function logic [7:0] type_code(logic [4:0] k);
			case (k)
				KIND_A:  return 8'h8e;
				KIND_B:  return 8'h85;
				KIND_C:  return 8'h87;
				KIND_D:  return 8'h8f;
				KIND_F:  return 8'h8a;
				KIND_I:  return 8'h8c;
				KIND_O:  return 8'h8b;
				KIND_N:  return 8'h89;
				KIND_R:  return 8'h88;
				KIND_S:  return 8'h84;
				KIND_ST: return 8'h8d;
				KIND_T:  return 8'h86;
				default: return 8'h00;
			endcase
		endfunction

		// key holds the lowered text right-justified, first character highest
		function int mnemonic_value(logic [4:0] k, logic [31:0] key);
			case (k)
				KIND_BT: case (key)
					"con": return 0; "rlen": return 1; "dlen": return 2;
					"df": return 3; "elem": return 4; "rgs": return 5;
					default: return -1;
				endcase
				KIND_C, KIND_T: case (key)
					"con": return 0; "pre": return 1; "acc": return 2;
					default: return -1;
				endcase
				KIND_R: case (key)
					"con": return 0; "len": return 1; "pos": return 2;
					default: return -1;
				endcase
				KIND_PD: case (key)
					"con": return 0; "sp": return 2; "kp": return 4;
					"ki": return 6; "kd": return 8; "pv": return 26;
					default: return -1;
				endcase
				KIND_MG: case (key)
					"con": return 0; "err": return 1; "rlen": return 2; "dlen": return 3;
					default: return -1;
				endcase
				KIND_ST: case (key)
					"len": return 0; "data": return 1;
					default: return -1;
				endcase
				default: return -1;
			endcase
		endfunction

		function void fail_parse();
			err = 1'b1;
			phase = P_DONE;
		endfunction

		function void fail_type();
			kind = KIND_UNKNOWN;
			fail_parse();
		endfunction

		function void start_file(logic [7:0] c);
			if (is_digit(c)) begin
				file_no = {12'd0, c - 8'h30};
				phase = P_FILE;
			end else begin
				fail_parse();
			end
		endfunction

		// the buffer never holds a zero byte, so the key also fixes the length
		function void resolve_mnemonic();
			logic [31:0] key;
			int          v;
			key = '0;
			for (int j = 0; j < mnem_len; j++) key = {key[23:0], lower(mnem[j])};
			v = mnemonic_value(kind, key);
			if (v < 0) begin
				fail_parse();
			end else begin
				sub_num = 20'(v);
				phase = P_DONE;
			end
		endfunction

		function void feed(logic [7:0] c);
			logic [7:0] l;
			l = lower(c);
			case (phase)
				P_TYPE: begin
					phase = P_FILE_FIRST;
					case (l)
						"a": kind = KIND_A;
						"b": begin kind = KIND_B; phase = P_TYPE2; end
						"c": kind = KIND_C;
						"d": kind = KIND_D;
						"f": kind = KIND_F;
						"i": kind = KIND_I;
						"m": begin kind = KIND_MG; phase = P_TYPE2; end
						"n": kind = KIND_N;
						"o": kind = KIND_O;
						"p": begin kind = KIND_PD; phase = P_TYPE2; end
						"r": kind = KIND_R;
						"s": begin kind = KIND_S; phase = P_TYPE2; end
						"t": kind = KIND_T;
						default: fail_type();
					endcase
				end
				P_TYPE2: begin
					if (kind == KIND_B || kind == KIND_S) begin
						// a digit right after B or S keeps the one-letter type
						if (is_digit(c)) start_file(c);
						else if (kind == KIND_B && l == "t") begin
							kind = KIND_BT; phase = P_FILE_FIRST;
						end else if (kind == KIND_S && l == "c") begin
							kind = KIND_SC; phase = P_FILE_FIRST;
						end else if (kind == KIND_S && l == "t") begin
							kind = KIND_ST; phase = P_FILE_FIRST;
						end else fail_type();
					end else if ((kind == KIND_MG && l == "g") || (kind == KIND_PD && l == "d")) begin
						phase = P_FILE_FIRST;
					end else begin
						fail_type();
					end
				end
				P_FILE_FIRST: start_file(c);
				P_FILE: begin
					if (is_digit(c) && file_no < NUM_LIMIT) file_no = shift_in(file_no, c);
					else if (c == ":") phase = P_ELEM;
					else fail_parse();
				end
				P_ELEM: begin
					if (is_digit(c) && elem_no < NUM_LIMIT) elem_no = shift_in(elem_no, c);
					else if (c == "/") begin
						has_sub = 1'b1; sub_num = '0; phase = P_BIT;
					end else if (c == ".") begin
						has_sub = 1'b1; phase = P_MNEM;
					end else if (c == 8'h00) phase = P_DONE;
					else fail_parse();
				end
				P_BIT: begin
					if (is_digit(c) && sub_num < NUM_LIMIT) sub_num = shift_in(sub_num, c);
					else phase = P_DONE;
				end
				P_MNEM: begin
					if (c == 8'h00) resolve_mnemonic();
					else if (mnem_len < 4) begin
						mnem[mnem_len] = c; mnem_len++;
					end else fail_parse();
				end
				default: ;
			endcase
		endfunction

		// short numbers take one byte, longer ones an escape and 16 bits low byte first
		function void put_num(logic [19:0] v);
			if (v <= NUM_ONE_BYTE_MAX) begin
				run_q.push_back(v[7:0]);
			end else begin
				run_q.push_back(NUM_ESC);
				run_q.push_back(v[7:0]);
				run_q.push_back(v[15:8]);
			end
		endfunction

		// one character taken by the slave side
		function void note_input(logic [7:0] c, logic l);
			status_t    st;
			logic [7:0] tc;
			feed(c);
			if (!l) return;
			if (phase != P_DONE) feed(8'h00);
			tc = type_code(kind);
			if (err) st = ST_BAD;
			else if (capacity < MIN_CAPACITY) st = ST_CAP;
			else if (fmt == FMT_TYPED && tc == 8'h00) st = ST_TYPE;
			else st = ST_OK;
			addresses++;
			if (st != ST_OK) begin
				rejected++;
				expected_q.push_back(enc_byte_t'{8'h00, 1'b1, st, kind});
			end else begin
				run_q.delete();
				if (fmt == FMT_LEVEL) begin
					run_q.push_back(has_sub ? FLAG_LEVEL_SUB : FLAG_LEVEL);
					put_num(file_no);
					put_num(elem_no);
					if (has_sub) put_num(sub_num);
				end else begin
					put_num(file_no);
					put_num({12'd0, tc});
					put_num(elem_no);
					put_num(has_sub ? sub_num : 20'd0);
				end
				foreach (run_q[i])
					expected_q.push_back(enc_byte_t'{run_q[i], i == run_q.size() - 1, ST_OK, kind});
			end
			clear();
		endfunction

		// one byte taken from the master side
		function void check_result(logic [7:0] data, logic last, logic [6:0] user);
			enc_byte_t e;
			bytes_checked++;
			if (expected_q.size() == 0) begin
				fails++;
				$display("%0t unexpected byte: expected none, got byte %02h last %0b tuser %02h",
					$time, data, last, user);
				return;
			end
			e = expected_q.pop_front();
			if (e.data !== data || e.last !== last || e.status !== user[1:0] ||
					e.kind !== user[6:2]) begin
				fails++;
				$display({"%0t mismatch: expected byte %02h last %0b status %0d kind %0d, ",
					"got byte %02h last %0b status %0d kind %0d"},
					$time, e.data, e.last, e.status, e.kind, data, last, user[1:0], user[6:2]);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;   // [7:0] char_in
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;           // [7:0] out_byte
	logic [6:0] m_tuser;           // [1:0] status, [6:2] data_file_kind
	logic       m_tlast;
	logic       cfg_we = 1'b0;
	logic       cfg_index = 1'b0;
	logic [7:0] cfg_data = 8'h00;

	addr_scoreboard sb;
	bit          idle_on = 1'b1;
	int          chars_sent = 0;
	int          settings = 0;
	logic [7:0]  addr_q[$];

	// type letters and mnemonics, paired so a valid suffix can be chosen with its type
	string mn_type [MNEM_COUNT] = '{"BT", "BT", "BT", "BT", "BT", "BT", "C", "C", "C",
		"T", "T", "T", "R", "R", "R", "PD", "PD", "PD", "PD", "PD", "PD",
		"MG", "MG", "MG", "MG", "ST", "ST"};
	string mn_text [MNEM_COUNT] = '{"con", "rlen", "dlen", "df", "elem", "rgs", "con", "pre",
		"acc", "con", "pre", "acc", "con", "len", "pos", "con", "sp", "kp", "ki", "kd", "pv",
		"con", "err", "rlen", "dlen", "len", "data"};
	string type_name [16] = '{"A", "B", "BT", "C", "D", "F", "I", "O", "MG", "N", "PD", "R",
		"S", "SC", "ST", "T"};
	string bad_type [4] = '{"Q", "BX", "MX", "P1"};

	pccc_logical_address_encoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// master side: check every transfer, then pick the next ready level
	// a stall burst starts at random; none once idling is switched off
	int stall_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast, m_tuser);
			if (stall_left > 0) begin
				stall_left = stall_left - 1;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 9);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// hang detector: any transfer on either side restarts the count
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < HANG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
			else quiet++;
		end
		$display("%0t no transfer for %0d cycles, %0d bytes still pending",
			$time, HANG_LIMIT, sb.pending());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// one character transfer, with an optional random gap in front
	// called just after a rising edge; returns just after the accepting edge
	task automatic push_char(input logic [7:0] c, input logic l);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= l;
		do @(posedge clk); while (!s_tready);
		sb.note_input(c, l);
		chars_sent++;
	endtask

	// the collected address, last_char on its final character
	task automatic send_bytes();
		foreach (addr_q[i]) push_char(addr_q[i], i == addr_q.size() - 1);
	endtask

	// letters get a random case where mix is set
	task automatic append_str(input string s, input bit mix);
		logic [7:0] c;
		for (int k = 0; k < s.len(); k++) begin
			c = s[k];
			if (mix && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")))
				c = $urandom_range(0, 1) ? (c | 8'h20) : (c & 8'hdf);
			addr_q.push_back(c);
		end
	endtask

	task automatic send_text(input string s);
		addr_q.delete();
		append_str(s, 1'b0);
		send_bytes();
	endtask

	// mostly short numbers; some cross the one-byte form, the 16-bit wrap and the digit limit
	function automatic string num_text();
		int unsigned v;
		string       s;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: v = $urandom_range(0, 30);
			5, 6:          v = $urandom_range(31, 999);
			7:             v = $urandom_range(65530, 65540);
			8:             v = $urandom_range(60000, 99999);
			default:       v = $urandom_range(100000, 9999999);
		endcase
		s = $sformatf("%0d", v);
		if ($urandom_range(0, 15) == 0) s = {"0", s};
		return s;
	endfunction

	// mostly well-formed addresses with random content, some broken, some pure noise
	task automatic send_random_address();
		int    r;
		int    i;
		int    n;
		string t;
		addr_q.delete();
		r = $urandom_range(0, 99);
		if (r < 8) begin
			n = $urandom_range(1, 6);
			repeat (n) addr_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			i = $urandom_range(0, MNEM_COUNT - 1);
			if (r < 35) t = mn_type[i];
			else if (r < 40) t = bad_type[$urandom_range(0, 3)];
			else t = type_name[$urandom_range(0, 15)];
			append_str(t, 1'b1);
			if ($urandom_range(0, 19) != 0) append_str(num_text(), 1'b0);
			if ($urandom_range(0, 19) != 0) append_str(":", 1'b0);
			else addr_q.push_back(8'($urandom_range(0, 255)));
			// an empty element number stands for element zero
			if ($urandom_range(0, 6) != 0) append_str(num_text(), 1'b0);
			if (r < 35) begin
				append_str(".", 1'b0);
				append_str(mn_text[i], 1'b1);
			end else begin
				case ($urandom_range(0, 9))
					4, 5: begin
						append_str("/", 1'b0);
						if ($urandom_range(0, 4) != 0) append_str(num_text(), 1'b0);
						if ($urandom_range(0, 4) == 0) addr_q.push_back(8'($urandom_range(0, 255)));
					end
					6, 7: begin
						append_str(".", 1'b0);
						append_str(mn_text[$urandom_range(0, MNEM_COUNT - 1)], 1'b1);
					end
					8: begin
						// arbitrary letters, often longer than the buffer
						append_str(".", 1'b0);
						repeat ($urandom_range(1, 6)) addr_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
					end
					9: addr_q.push_back(8'($urandom_range(0, 255)));
					default: ;
				endcase
			end
			// a zero byte ends the text, anything after it is ignored
			if ($urandom_range(0, 9) == 0) begin
				addr_q.push_back(8'h00);
				repeat ($urandom_range(0, 3)) addr_q.push_back(8'($urandom_range(0, 255)));
			end
		end
		send_bytes();
	endtask

	// hold off the sender until every owed byte has left and the pipeline is empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// both registers, one write per cycle
	task automatic write_regs(input logic f, input logic [7:0] cap);
		cfg_we <= 1'b1;
		cfg_index <= REG_FORMAT;
		cfg_data <= {7'd0, f};
		@(posedge clk);
		cfg_index <= REG_CAPACITY;
		cfg_data <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.fmt = f;
		sb.capacity = cap;
		settings++;
	endtask

	initial begin : stimulus
		logic       plan_fmt [8];
		logic [7:0] plan_cap [8];
		logic       f;
		logic [7:0] cap;
		int         start;
		plan_fmt = '{FMT_LEVEL, FMT_TYPED, FMT_TYPED, FMT_LEVEL, FMT_TYPED, FMT_LEVEL,
			FMT_TYPED, FMT_LEVEL};
		plan_cap = '{8'd12, 8'd12, 8'd255, 8'd10, 8'd9, 8'd0, 8'd10, 8'd255};
		sb = new();
		settings = 1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under the reset settings: mnemonic in upper case, empty bit,
		// empty element, unknown type letter, a character with the top bit set,
		// status-table type in mixed case
		send_text("T4:1.ACC");
		send_text("b3:2/");
		send_text("N7:");
		send_text("x");
		addr_q.delete();
		addr_q.push_back(8'hff);
		send_bytes();
		send_text("sT2:");

		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			if (p < 8) begin
				f = plan_fmt[p];
				cap = plan_cap[p];
			end else begin
				f = 1'($urandom_range(0, 1));
				cap = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 9)) :
					8'($urandom_range(10, 255));
			end
			write_regs(f, cap);
			// the closing stretch runs with both sides at full rate
			if (p == NUM_PHASES - 1) idle_on = 1'b0;
			start = chars_sent;
			while (chars_sent - start < PHASE_CHARS) send_random_address();
		end
		settle();

		$display("run covered %0d characters in %0d addresses (%0d rejected) under %0d settings",
			chars_sent, sb.addresses, sb.rejected, settings);
		$display("%0d output bytes checked, %0d mismatches", sb.bytes_checked, sb.fails);
		if (sb.fails == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
